### src/lkvc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Field widths, transaction structs and controller command bundle.
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int CFG_BITS    = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } out_item_t;

  typedef struct packed {
    logic capture;  // latch lookup results for the accepted transaction
    logic commit;   // apply the update and emit the result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

### src/lkvc_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_ctrl: cache controller
// Two-state sequencer: accept and look up, then commit the update.
// ---------------------------------------------------------------------------
module lkvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output lkvc_pkg::ctrl_cmd_t    ctl
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign ctl.capture = (state_r == ST_IDLE) && start;
  assign ctl.commit  = (state_r == ST_UPDATE);

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_commit_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> ctl.commit)
    else $error("commit did not follow capture");

  a_commit_single: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> !ctl.commit)
    else $error("commit held for more than one cycle");

endmodule
`default_nettype wire

### src/lkvc_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lkvc_dpath: cache datapath
// Key compare lanes, recency ranks, value memory and result register.
// ---------------------------------------------------------------------------
module lkvc_dpath #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lkvc_pkg::ctrl_cmd_t           ctl,
  input  wire lkvc_pkg::in_item_t            req,
  input  wire logic                          cfg_we,
  input  wire logic [lkvc_pkg::CFG_BITS-1:0] cfg_data,
  output logic                               res_valid,
  output lkvc_pkg::out_item_t                res
);
  import lkvc_pkg::*;

  localparam int RW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > CFG_BITS) ? CW : CFG_BITS;

  // stored state
  logic [ENTRIES-1:0]    valid_r, valid_nxt;
  logic [KEY_BITS-1:0]   keys_r [ENTRIES];
  logic [RW-1:0]         rank_r [ENTRIES];
  logic [RW-1:0]         rank_nxt [ENTRIES];
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [CFG_BITS-1:0]   cap_r;
  logic [VALUE_BITS-1:0] mem [ENTRIES];
  logic [VALUE_BITS-1:0] rd_r;

  // lookup
  logic [ENTRIES-1:0]    hit_vec, lru_vec;
  logic                  hit_any;
  logic [RW-1:0]         hit_idx, lru_idx, hit_rank;
  logic [KEY_BITS-1:0]   lru_key;
  logic [CW-1:0]         occ_m1;
  logic [RW-1:0]         occ_last;
  logic [CAPW-1:0]       cap_ext, cap_eff, occ_ext;
  logic                  is_put, do_fill, do_evict;
  logic [RW-1:0]         slot;

  // captured transaction
  logic                  put_r, hit_r, fill_r, evict_r;
  logic [KEY_BITS-1:0]   key_r, ev_key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [RW-1:0]         slot_r, old_rank_r;

  // result
  logic                  out_valid_r;
  out_item_t             out_r;

  assign occ_m1   = occ_r - CW'(1);
  assign occ_last = occ_m1[RW-1:0];

  // Valid entries always form a prefix, and their ranks are a permutation of
  // 0..occ-1, so the least recent entry is the one ranked occ-1.
  always_comb begin
    hit_idx  = '0;
    lru_idx  = '0;
    hit_rank = '0;
    lru_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (keys_r[i] == req.key);
      lru_vec[i] = valid_r[i] && (rank_r[i] == occ_last);
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | RW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru_vec[i]) begin
        lru_idx = lru_idx | RW'(i);
        lru_key = lru_key | keys_r[i];
      end
    end
  end

  assign hit_any = |hit_vec;

  always_comb begin
    cap_ext = CAPW'(cap_r);
    occ_ext = CAPW'(occ_r);
    if (cap_ext == '0) begin
      cap_eff = CAPW'(1);
    end else if (cap_ext > CAPW'(ENTRIES)) begin
      cap_eff = CAPW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign is_put   = (req.cmd == CMD_PUT);
  assign do_fill  = is_put && !hit_any && (occ_ext < cap_eff);
  assign do_evict = is_put && !hit_any && !do_fill;
  assign slot     = hit_any ? hit_idx : (do_fill ? occ_r[RW-1:0] : lru_idx);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      put_r      <= is_put;
      hit_r      <= hit_any;
      fill_r     <= do_fill;
      evict_r    <= do_evict;
      key_r      <= req.key;
      val_r      <= req.value;
      slot_r     <= slot;
      old_rank_r <= hit_any ? hit_rank : occ_last;
      ev_key_r   <= lru_key;
    end
  end

  // value memory: read at lookup, written at commit
  always_ff @(posedge clk) begin
    if (ctl.commit && (fill_r || evict_r || (hit_r && put_r))) begin
      mem[slot_r] <= val_r;
    end
    if (ctl.capture) begin
      rd_r <= mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && (fill_r || evict_r)) begin
      keys_r[slot_r] <= key_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    occ_nxt   = occ_r;
    if (ctl.commit) begin
      if (fill_r) begin
        // age every resident entry, new one becomes most recent
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) rank_nxt[i] = rank_r[i] + RW'(1);
        end
        valid_nxt[slot_r] = 1'b1;
        rank_nxt[slot_r]  = '0;
        occ_nxt           = occ_r + CW'(1);
      end else if (hit_r || evict_r) begin
        // age only entries more recent than the touched one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (RW'(i) != slot_r) && (rank_r[i] < old_rank_r)) begin
            rank_nxt[i] = rank_r[i] + RW'(1);
          end
        end
        rank_nxt[slot_r] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      rank_r  <= rank_nxt;
      if (cfg_we) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_r.found       <= hit_r;
      out_r.read_value  <= (hit_r && !put_r) ? rd_r : '0;
      out_r.evicted     <= evict_r;
      out_r.evicted_key <= evict_r ? ev_key_r : '0;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key resident in more than one entry");

  a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lru_vec))
    else $error("more than one least recent entry");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("valid marks disagree with occupancy count");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.capture && do_evict) |-> (lru_vec != '0))
    else $error("eviction without a least recent entry");

endmodule
`default_nettype wire

### src/lru_key_value_cache_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative LRU key-value cache
// Get/put transactions against a small store with least-recently-used
// replacement and a programmable capacity.
// ---------------------------------------------------------------------------
// Result: the commit state is registered into the result strobe out_valid.
// Each transaction has a lookup phase (parallel key compare and value memory
//   read) and a commit phase (rank update, write); no start is taken in commit.
// busy is high for the commit cycle only; the result register lets the next
//   start be accepted while the previous result is on the output.
// Reset (rst_n low, synchronous): cache empty, capacity_in_use = 16.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request transaction
  input  wire logic                          start,
  output logic                               busy,
  input  wire lkvc_pkg::in_item_t            in_req,
  // result transaction, one cycle strobe, no back-pressure
  output logic                               out_valid,
  output lkvc_pkg::out_item_t                out_res,
  // capacity register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lkvc_pkg::CFG_BITS-1:0] cfg_data
);
  import lkvc_pkg::*;

  ctrl_cmd_t ctl;

  // Always take configuration; user ensures it is written only while idle (unenforced).
  assign cfg_ready = 1'b1;

  // Sequence accept -> commit.
  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Look up on accept, update state and drive the result on commit.
  lkvc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .req       (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (out_valid),
    .res       (out_res)
  );

  // an accepted request raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // every accepted transaction yields a result strobe via the commit state and result register
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing");

  // result strobe lands in an idle cycle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

endmodule
`default_nettype wire
